// ===== hw/rtl/grc_pkg.sv =====
// ----------------------------------------------------------------------------
// grc_pkg: shared types and constants of the raycast column engine
// Palette, register indexes, map and screen sizes and the hit record struct.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int unsigned ONE_Q12 = 4096;
  localparam int unsigned ONE_Q14 = 16384;

  localparam int unsigned MAP_SIZE      = 16;
  localparam int unsigned SCREEN_WIDTH  = 1280;
  localparam int unsigned SCREEN_HEIGHT = 720;

  localparam logic [2:0] REG_POS_X   = 3'd0;
  localparam logic [2:0] REG_POS_Y   = 3'd1;
  localparam logic [2:0] REG_DIR_X   = 3'd2;
  localparam logic [2:0] REG_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;

  localparam logic CMD_CAST  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [31:0] SHADE_MASK = 32'h7F7F7FFF;

  typedef struct packed {
    logic        hit;
    logic        full;
    logic        side;
    logic [2:0]  id;
  } grc_hit_t;

  function automatic logic [31:0] colour_of(input logic [2:0] id, input logic side);
    logic [31:0] c;
    case (id)
      3'd1:    c = 32'hAAAAAAFF;
      3'd2:    c = 32'hFF5555FF;
      3'd3:    c = 32'h55FF55FF;
      3'd4:    c = 32'h5555FFFF;
      default: c = 32'h000000FF;
    endcase
    if (side) c = (c >> 1) & SHADE_MASK;
    return c;
  endfunction

endpackage

// ===== hw/rtl/grid_raycast_column.sv =====
// ----------------------------------------------------------------------------
// grid_raycast_column: DDA raycaster, one screen column per cast item
// Map writes and column casts share one command channel.
// ----------------------------------------------------------------------------
// Usage:
//  An item is taken when start is high and busy low. A write item (in_cmd 1)
//  stores one wall id and gives no result; busy rises for one cycle.
//  A cast item raises busy until its result has been shown: out_valid is
//  high for exactly one cycle with the span, colour and hit flags.
//  Steps: ray setup (camera value by reciprocal multiply and one correction,
//  then the plane products), then per map cell walked the products, the step
//  with map read and the check, then the wall height on the iterative divider
//  and the output state. A wall at the viewer, on the grid line or head-on
//  skips the divider; a ray leaving the grid or finding no wall within
//  MAX_STEPS cells ends the walk with no wall.
//  One cast at a time; the walk loop and the divider set the throughput.
//  The receiver cannot stall; results are never held.
//  Reset restores the viewer registers; the map is undefined until written.
//  Configuration through the APB port while no item is in flight.
// ----------------------------------------------------------------------------
module grid_raycast_column #(
  parameter int unsigned MAX_STEPS     = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [10:0] in_column,
  input  logic [7:0]  in_cell_index,
  input  logic [2:0]  in_cell_value,
  output logic        out_valid,
  output logic [10:0] out_out_column,
  output logic [9:0]  out_span_top,
  output logic [9:0]  out_span_bottom,
  output logic [31:0] out_wall_rgba,
  output logic        out_hit_side,
  output logic        out_hit_found,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int unsigned MAP_SIZE      = grc_pkg::MAP_SIZE;
  localparam int unsigned SCREEN_WIDTH  = grc_pkg::SCREEN_WIDTH;
  localparam int unsigned SCREEN_HEIGHT = grc_pkg::SCREEN_HEIGHT;
  localparam int unsigned MB    = $clog2(MAP_SIZE);
  localparam int unsigned AW    = 2 * MB;
  localparam int unsigned CELLS = MAP_SIZE * MAP_SIZE;
  localparam int unsigned SB    = $clog2(MAX_STEPS + 1);
  localparam int unsigned HALF  = SCREEN_HEIGHT / 2;
  localparam logic [31:0] CAM_RECIP = 32'(64'h1_0000_0000 / 64'(SCREEN_WIDTH));

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CAM   = 10'b0000000010,
    S_RAY   = 10'b0000000100,
    S_FIRST = 10'b0000001000,
    S_CMP   = 10'b0000010000,
    S_STEP  = 10'b0000100000,
    S_READ  = 10'b0001000000,
    S_HDIV  = 10'b0010000000,
    S_HWAIT = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r;

  // configuration registers
  logic [15:0] pos_x_r, pos_y_r, dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= 16'd30720;
      pos_y_r   <= 16'd30720;
      dir_x_r   <= 16'd16384;
      dir_y_r   <= 16'd0;
      plane_x_r <= 16'd0;
      plane_y_r <= 16'd10813;
    end else if (cfg_wr) begin
      case (cfg_idx)
        grc_pkg::REG_POS_X:   pos_x_r   <= cfg_pwdata[15:0];
        grc_pkg::REG_POS_Y:   pos_y_r   <= cfg_pwdata[15:0];
        grc_pkg::REG_DIR_X:   dir_x_r   <= cfg_pwdata[15:0];
        grc_pkg::REG_DIR_Y:   dir_y_r   <= cfg_pwdata[15:0];
        grc_pkg::REG_PLANE_X: plane_x_r <= cfg_pwdata[15:0];
        grc_pkg::REG_PLANE_Y: plane_y_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      grc_pkg::REG_POS_X:   cfg_prdata = {16'd0, pos_x_r};
      grc_pkg::REG_POS_Y:   cfg_prdata = {16'd0, pos_y_r};
      grc_pkg::REG_DIR_X:   cfg_prdata = {16'd0, dir_x_r};
      grc_pkg::REG_DIR_Y:   cfg_prdata = {16'd0, dir_y_r};
      grc_pkg::REG_PLANE_X: cfg_prdata = {16'd0, plane_x_r};
      grc_pkg::REG_PLANE_Y: cfg_prdata = {16'd0, plane_y_r};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  // divider for the wall height
  logic        div_start;
  logic [31:0] div_a, div_b, div_q;
  logic        div_done;

  grc_div #(.W(32)) u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  // map store
  logic          map_we;
  logic [AW-1:0] map_waddr, map_raddr;
  logic [2:0]    map_rdata;

  grc_map #(.AW(AW)) u_map (
    .clk, .we(map_we), .waddr(map_waddr), .wdata(in_cell_value),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  logic accept;
  assign accept    = start && !busy;
  assign map_we    = accept && in_cmd == grc_pkg::CMD_WRITE &&
                     {24'd0, in_cell_index} < 32'(CELLS);
  assign map_waddr = in_cell_index[AW-1:0];

  // datapath registers
  logic [10:0]        col_r;
  logic               camneg_r;
  logic [12:0]        camag_r;
  logic [26:0]        camq_r;
  logic signed [17:0] cam_r;
  logic signed [34:0] prx_r, pry_r;
  logic signed [18:0] rx_r, ry_r;
  logic [17:0]        ax_r, ay_r;
  logic signed [MB+1:0] mx_r, my_r;
  logic [21:0]        dx_r, dy_r;
  logic [39:0]        ldx_r, ldy_r;
  logic [SB-1:0]      n_r;
  grc_pkg::grc_hit_t  hit_r;
  logic               wr_busy_r;
  logic               prod_r;

  logic signed [34:0] rx_full, ry_full;
  logic [11:0]        cell_x, cell_y;
  logic               outside;
  logic               stepx;
  logic signed [MB+1:0] nmx, nmy;
  logic               oob;
  logic [12:0]        camag;
  logic [44:0]        cam_prod;
  logic [39:0]        cam_rem;
  logic [26:0]        cam_q;
  logic [21:0]        numv;
  logic [17:0]        rsel;
  logic [31:0]        lh32;
  logic [31:0]        top_w, bot_w;

  assign cell_x  = 12'(pos_x_r >> 12);
  assign cell_y  = 12'(pos_y_r >> 12);
  assign outside = {20'd0, cell_x} >= 32'(MAP_SIZE) || {20'd0, cell_y} >= 32'(MAP_SIZE);

  // |2*col - W|
  assign camag = ({1'b0, in_column, 1'b0} >= 13'(SCREEN_WIDTH)) ?
                 {1'b0, in_column, 1'b0} - 13'(SCREEN_WIDTH) :
                 13'(SCREEN_WIDTH) - {1'b0, in_column, 1'b0};

  // |2*col - W| * 16384 / W: reciprocal estimate is low by at most one
  assign cam_prod = 45'(camag_r) * 45'(CAM_RECIP);
  assign cam_rem  = {13'd0, camag_r, 14'd0} - 40'(camq_r) * 40'(SCREEN_WIDTH);
  assign cam_q    = cam_rem >= 40'(SCREEN_WIDTH) ? camq_r + 27'd1 : camq_r;

  // truncating division of plane*cam by 16384 (toward zero)
  function automatic logic signed [34:0] tdiv14(input logic signed [34:0] v);
    logic signed [34:0] a;
    a = v < 0 ? -v : v;
    a = a >>> 14;
    return v < 0 ? -a : a;
  endfunction

  assign rx_full = 35'(signed'(dir_x_r)) + tdiv14(prx_r);
  assign ry_full = 35'(signed'(dir_y_r)) + tdiv14(pry_r);

  assign stepx = ldx_r < ldy_r;
  assign nmx   = (MB+2)'(mx_r + (rx_r < 0 ? -1 : 1));
  assign nmy   = (MB+2)'(my_r + (ry_r < 0 ? -1 : 1));

  always_comb begin
    oob = 1'b0;
    if (stepx) oob = nmx < 0 || nmx >= (MB+2)'(MAP_SIZE);
    else       oob = nmy < 0 || nmy >= (MB+2)'(MAP_SIZE);
  end

  assign numv = hit_r.side ? dy_r - 22'(grc_pkg::ONE_Q12) : dx_r - 22'(grc_pkg::ONE_Q12);
  assign rsel = hit_r.side ? ay_r : ax_r;

  always_comb begin
    map_raddr = {cell_y[MB-1:0], cell_x[MB-1:0]};
    if (state_r == S_STEP) begin
      if (stepx) map_raddr = {my_r[MB-1:0], nmx[MB-1:0]};
      else       map_raddr = {nmy[MB-1:0], mx_r[MB-1:0]};
    end
  end

  assign div_start = state_r == S_HDIV;
  assign div_a     = 32'(SCREEN_HEIGHT) * {14'd0, rsel};
  assign div_b     = {8'd0, numv, 2'b00};

  assign lh32  = div_q;
  assign top_w = (lh32 >> 1) > 32'(HALF) ? 32'd0 : 32'(HALF) - (lh32 >> 1);
  assign bot_w = 32'(HALF) + (lh32 >> 1) >= 32'(SCREEN_HEIGHT) ?
                 32'(SCREEN_HEIGHT - 1) : 32'(HALF) + (lh32 >> 1);

  logic [9:0]  top_r, bot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wr_busy_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      wr_busy_r <= accept && in_cmd == grc_pkg::CMD_WRITE;
      case (state_r)
        S_IDLE: begin
          if (accept && in_cmd == grc_pkg::CMD_CAST) begin
            col_r    <= in_column;
            camag_r  <= camag;
            camneg_r <= {1'b0, in_column, 1'b0} < 13'(SCREEN_WIDTH);
            prod_r   <= 1'b0;
            state_r  <= S_CAM;
          end
        end
        S_CAM: begin
          if (!prod_r) begin
            camq_r <= 27'(cam_prod >> 18);
            prod_r <= 1'b1;
          end else begin
            cam_r   <= camneg_r ? -18'(signed'({1'b0, cam_q[16:0]})) :
                                   18'(signed'({1'b0, cam_q[16:0]}));
            prod_r  <= 1'b0;
            state_r <= S_RAY;
          end
        end
        S_RAY: begin
          if (!prod_r) begin
            prx_r  <= 35'(signed'(plane_x_r)) * 35'(cam_r);
            pry_r  <= 35'(signed'(plane_y_r)) * 35'(cam_r);
            prod_r <= 1'b1;
          end else begin
            rx_r <= 19'(rx_full);
            ry_r <= 19'(ry_full);
            ax_r <= rx_full < 0 ? 18'(-rx_full) : 18'(rx_full);
            ay_r <= ry_full < 0 ? 18'(-ry_full) : 18'(ry_full);
            dx_r <= rx_full < 0 ? 22'(pos_x_r[11:0]) : 22'(13'd4096 - {1'b0, pos_x_r[11:0]});
            dy_r <= ry_full < 0 ? 22'(pos_y_r[11:0]) : 22'(13'd4096 - {1'b0, pos_y_r[11:0]});
            mx_r <= (MB+2)'(cell_x);
            my_r <= (MB+2)'(cell_y);
            n_r  <= '0;
            hit_r <= '0;
            state_r <= S_FIRST;
          end
        end
        S_FIRST: begin
          // map word for the viewer cell is now on rdata
          if (outside) begin
            state_r <= S_OUT;
          end else if (map_rdata != 3'd0) begin
            hit_r   <= '{hit: 1'b1, full: 1'b1, side: 1'b0, id: map_rdata};
            state_r <= S_OUT;
          end else begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          ldx_r   <= 40'(dx_r) * 40'(ay_r);
          ldy_r   <= 40'(dy_r) * 40'(ax_r);
          state_r <= (n_r == SB'(MAX_STEPS)) ? S_OUT : S_STEP;
        end
        S_STEP: begin
          n_r <= n_r + 1'b1;
          if (stepx) begin
            mx_r <= nmx;
            dx_r <= dx_r + 22'(grc_pkg::ONE_Q12);
            hit_r.side <= 1'b0;
          end else begin
            my_r <= nmy;
            dy_r <= dy_r + 22'(grc_pkg::ONE_Q12);
            hit_r.side <= 1'b1;
          end
          state_r <= oob ? S_OUT : S_READ;
        end
        S_READ: begin
          if (map_rdata != 3'd0) begin
            hit_r.hit <= 1'b1;
            hit_r.id  <= map_rdata;
            if (rsel == 18'd0) begin
              top_r   <= 10'(HALF);
              bot_r   <= 10'(HALF);
              state_r <= S_OUT;
            end else if (numv == 22'd0) begin
              hit_r.full <= 1'b1;
              state_r    <= S_OUT;
            end else begin
              state_r <= S_HDIV;
            end
          end else begin
            state_r <= S_CMP;
          end
        end
        S_HDIV: state_r <= S_HWAIT;
        S_HWAIT: begin
          if (div_done) begin
            top_r   <= 10'(top_w);
            bot_r   <= 10'(bot_w);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid       <= 1'b1;
          out_out_column  <= col_r;
          out_hit_found   <= hit_r.hit;
          out_hit_side    <= hit_r.hit && hit_r.side;
          out_wall_rgba   <= hit_r.hit ? grc_pkg::colour_of(hit_r.id, hit_r.side) : 32'd0;
          out_span_top    <= (!hit_r.hit || hit_r.full) ? 10'd0 : top_r;
          out_span_bottom <= !hit_r.hit ? 10'd0 :
                             hit_r.full ? 10'(SCREEN_HEIGHT - 1) : bot_r;
          state_r         <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = state_r != S_IDLE || wr_busy_r;

  // the step counter never passes its bound
  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= SB'(MAX_STEPS) || state_r == S_IDLE || state_r == S_CAM || state_r == S_RAY)
    else $error("step count beyond bound");
  // a result follows only from the output state
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_OUT)
    else $error("result without output state");
  // no item taken while a cast is in flight
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> busy)
    else $error("busy low during cast");

endmodule

// ===== hw/rtl/grc_div.sv =====
// ----------------------------------------------------------------------------
// grc_div: unsigned restoring divider
// One quotient bit per cycle; start pulses load, done pulses at the end.
// ----------------------------------------------------------------------------
module grc_div #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  q_r, d_r;
  logic [W:0]    rem_r;
  logic [CW-1:0] cnt_r;
  logic          act_r, done_r;
  logic [W:0]    trial;

  assign trial = {rem_r[W-1:0], q_r[W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        act_r <= 1'b1;
        cnt_r <= CW'(W);
        q_r   <= dividend;
        d_r   <= divisor;
        rem_r <= '0;
      end else if (act_r) begin
        if (trial >= {1'b0, d_r}) begin
          rem_r <= trial - {1'b0, d_r};
          q_r   <= {q_r[W-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          act_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== hw/rtl/grc_map.sv =====
// ----------------------------------------------------------------------------
// grc_map: wall id store
// Single write port, one registered read port.
// ----------------------------------------------------------------------------
module grc_map #(
  parameter int unsigned AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [2:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [2:0]    rdata
);
  logic [2:0] mem [2**AW];
  logic [2:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
